// ===== hdl/sprtab_pkg.sv =====
// ============================================================================
// sprtab_pkg
// Shared constants and types for the blank-run to tab compressor.
// ============================================================================
`default_nettype none

package sprtab_pkg;

    // Widest tab interval the hardware supports
    localparam int MAX_TAB_WIDTH = 16;

    // Width of the configuration register
    localparam int CFG_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int PHASE_W = $clog2(MAX_TAB_WIDTH);
    // Phase plus one, and the effective tab width, need one more bit
    localparam int EXT_W   = PHASE_W + 1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

    // Character codes
    localparam logic [BYTE_W-1:0] CH_BLANK   = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;

    // Command queue between the front and back halves
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One command: release this many blanks, then emit the byte
    typedef struct packed {
        logic [PHASE_W-1:0] blanks;
        logic [BYTE_W-1:0]  data;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hdl/sprtab_front.sv =====
// ============================================================================
// sprtab_front
// Accepts text bytes, tracks column phase and held blanks, issues commands.
// ============================================================================
`default_nettype none

module sprtab_front
    import sprtab_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic              i_accept,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    output t_cmd                   o_cmd,
    output logic                   o_cmd_push
);

    localparam int CMP_W = (CFG_W > EXT_W) ? CFG_W : EXT_W;

    logic [CFG_W-1:0]   r_tab_width;
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] r_held;
    logic [PHASE_W-1:0] n_phase;
    logic [PHASE_W-1:0] n_held;

    logic [CMP_W-1:0]   w_cfg_ext;
    logic [EXT_W-1:0]   w_eff_width;
    logic [EXT_W-1:0]   w_phase_inc;
    logic [EXT_W-1:0]   w_held_inc;
    logic               w_at_stop;
    logic               w_is_blank;

    // Clamp the configured width into 1..MAX_TAB_WIDTH
    always_comb begin
        w_cfg_ext = CMP_W'(r_tab_width);
        if (w_cfg_ext == '0) begin
            w_eff_width = EXT_W'(1);
        end else if (w_cfg_ext > CMP_W'(MAX_TAB_WIDTH)) begin
            w_eff_width = EXT_W'(MAX_TAB_WIDTH);
        end else begin
            w_eff_width = EXT_W'(w_cfg_ext);
        end
    end

    assign w_phase_inc = EXT_W'(r_phase) + EXT_W'(1);
    assign w_held_inc  = EXT_W'(r_held) + EXT_W'(1);
    assign w_at_stop   = (w_phase_inc >= w_eff_width);
    assign w_is_blank  = (i_in_byte == CH_BLANK);

    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        if (i_accept) begin
            if (w_is_blank) begin
                // Absorb the blank; at a stop, replace the run
                if (w_at_stop) begin
                    o_cmd_push  = 1'b1;
                    o_cmd.data  = (w_held_inc >= EXT_W'(2)) ? CH_TAB : CH_BLANK;
                    n_phase     = '0;
                    n_held      = '0;
                end else begin
                    n_phase = w_phase_inc[PHASE_W-1:0];
                    n_held  = w_held_inc[PHASE_W-1:0];
                end
            end else begin
                // Release held blanks ahead of the byte
                o_cmd_push   = 1'b1;
                o_cmd.data   = i_in_byte;
                o_cmd.blanks = r_held;
                n_held       = '0;
                if (i_in_byte == CH_TAB || i_in_byte == CH_NEWLINE || w_at_stop) begin
                    n_phase = '0;
                end else begin
                    n_phase = w_phase_inc[PHASE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_width <= CFG_RESET;
            r_phase     <= '0;
            r_held      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tab_width <= i_cfg_wr_data;
            end
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sprtab_queue.sv =====
// ============================================================================
// sprtab_queue
// Short command queue that decouples the front and back halves.
// ============================================================================
`default_nettype none

module sprtab_queue
    import sprtab_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sprtab_back.sv =====
// ============================================================================
// sprtab_back
// Expands queued commands into output bytes, one per cycle while the output is taken, into a register.
// ============================================================================
`default_nettype none

module sprtab_back
    import sprtab_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic               i_q_empty,
    output logic                    o_q_pop,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic [BYTE_W-1:0]       o_out_byte,
    output logic                    o_out_last
);

    logic               r_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_last;
    logic [PHASE_W-1:0] r_sent;
    logic               n_valid;
    logic [BYTE_W-1:0]  n_byte;
    logic               n_last;
    logic [PHASE_W-1:0] n_sent;
    logic               w_load;

    // Output slot frees up when empty or being taken this cycle
    assign w_load = !r_valid || i_pop;

    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        n_sent  = r_sent;
        o_q_pop = 1'b0;
        if (w_load) begin
            n_valid = !i_q_empty;
            if (!i_q_empty) begin
                if (r_sent != i_cmd.blanks) begin
                    n_byte = CH_BLANK;
                    n_last = 1'b0;
                    n_sent = r_sent + PHASE_W'(1);
                end else begin
                    n_byte  = i_cmd.data;
                    n_last  = 1'b1;
                    n_sent  = '0;
                    o_q_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= '0;
        end else begin
            r_valid <= n_valid;
            r_sent  <= n_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_empty    = !r_valid;
    assign o_out_byte = r_byte;
    assign o_out_last = r_last;

endmodule

`default_nettype wire

// ===== hdl/space_run_to_tab_compressor_top.sv =====
// ============================================================================
// space_run_to_tab_compressor_top
// Replaces runs of blanks with tabs and blanks at the configured tab stops.
// ============================================================================
// One text byte is taken per transfer on the push side and zero or more bytes
// come out on the pop side, the final one of each input flagged by
// o_out_last. The front half takes a byte every cycle while its four-entry
// command queue has room; a blank that does not reach a tab stop produces
// nothing. The back half drives the single output register and moves one
// result byte per cycle while pop takes it, so a byte that releases k held
// blanks yields k+1 result bytes, and sustained throughput is one result
// byte per clock, set by that output register. Write the tab width (0 acts
// as 1, values above 16 act as 16) only while the block is idle; it resets
// to 4.
`default_nettype none

module space_run_to_tab_compressor_top
    import sprtab_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    output logic                   empty,
    input  wire logic              pop,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_out_last
);

    t_cmd w_front_cmd;
    t_cmd w_head_cmd;
    logic w_cmd_push;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_pop;
    logic w_accept;

    // Take an input transfer only when the queue can hold its command
    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    sprtab_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_in_byte     (i_in_byte),
        .o_cmd         (w_front_cmd),
        .o_cmd_push    (w_cmd_push)
    );

    sprtab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_q_empty)
    );

    // Drain commands into the output register, one byte per cycle while the output is popped
    sprtab_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_head_cmd),
        .i_q_empty  (w_q_empty),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

`ifndef NO_ASSERTIONS
    // A command is only issued for an accepted byte
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> w_accept)
        else $error("command issued without an accepted byte");

    // The back half never drains an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("queue popped while empty");

    // Every result other than the last of an item is a released blank
    a_released_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_last) |-> (o_out_byte == CH_BLANK))
        else $error("non-final result is not a blank");
`endif

endmodule

`default_nettype wire
